/* sv/mas_pkg.sv */
// ----------------------------------------------------------------------------
// mas_pkg: shared types and constants of the square matrix unit
// Item structs for both channels, operation codes and field widths.
// ----------------------------------------------------------------------------
package mas_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 8;
    localparam int unsigned DATA_W          = 32;
    localparam int unsigned IDX_W           = 3;
    localparam int unsigned DIM_W           = 4;
    localparam int unsigned OP_W            = 3;

    // Operation codes; codes above OP_MUL are ignored by the block.
    localparam logic [OP_W-1:0] OP_LOAD_A = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [DATA_W-1:0] result;
        logic                     saturated;
        logic                     last;
    } t_out_item;

endpackage

/* sv/mas_ram.sv */
// ----------------------------------------------------------------------------
// mas_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mas_ram #(
    parameter int unsigned WIDTH  = 32,
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/matrix_add_sub_multiply.sv */
// ----------------------------------------------------------------------------
// matrix_add_sub_multiply: square matrix add, subtract and multiply
// Two stored Q16.16 matrices, element loads, streamed result matrices.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in_valid / o_in_stall with payload i_in_data. A load
// item writes one element of A or B and gives no result. A
// compute item (add, subtract, multiply) streams dim*dim result elements in
// row-major order on o_out_valid / i_out_stall, with last set on the final one.
// While a compute item is in progress the input side is stalled.
// Each element passes through the memory read, an operand stage (multiplier or
// adder) and the accumulator; a product element is summed by the single
// multiply-accumulate unit reading one A and one B word per cycle. The next
// item is taken the cycle after the last element enters the output register.
// A stalled receiver holds the output register, and the sequencer waits.
// The dim register (i_cfg_valid / o_cfg_ready) is always ready and must be
// written while the block is idle; the block itself does not enforce this.
// Reset sets dim to 8 and empties the pipeline; the matrix memories keep their
// contents and must be loaded before they are read.
// ----------------------------------------------------------------------------
module matrix_add_sub_multiply #(
    parameter int unsigned MAX_DIM = mas_pkg::MAX_DIM_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  mas_pkg::t_in_item       i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output mas_pkg::t_out_item      o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [mas_pkg::DIM_W-1:0] i_cfg_data
);

    import mas_pkg::*;

    localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned PROD_W = 2 * DATA_W;
    // Sum of up to eight full products plus a sign bit.
    localparam int unsigned ACC_W  = PROD_W + 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_FIN
    } t_state;

    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        logic [6:0] full;
        full = 7'(r) * 7'(MAX_DIM) + 7'(c);
        return full[ADDR_W-1:0];
    endfunction

    t_state                   r_state;
    logic [DIM_W-1:0]         r_dim;
    logic [OP_W-1:0]          r_op;
    logic [IDX_W-1:0]         r_last_idx;
    logic [IDX_W-1:0]         r_row;
    logic [IDX_W-1:0]         r_col;
    logic [IDX_W-1:0]         r_k;
    logic                     r_rd_vld;
    logic                     r_rd_first;
    logic                     r_rd_last;
    logic                     r_p_vld;
    logic                     r_p_first;
    logic                     r_p_last;
    logic signed [PROD_W-1:0] r_p;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_acc_done;
    logic                     r_out_vld;
    t_out_item                r_out;

    logic                     w_in_acc;
    logic                     w_is_mul;
    logic                     w_in_range;
    logic [DIM_W-1:0]         w_eff_dim;
    logic                     w_issue_last;
    logic                     w_out_free;
    logic [ADDR_W-1:0]        w_a_raddr;
    logic [ADDR_W-1:0]        w_b_raddr;
    logic [ADDR_W-1:0]        w_waddr;
    logic [DATA_W-1:0]        w_a_rdata;
    logic [DATA_W-1:0]        w_b_rdata;
    logic signed [DATA_W:0]   w_addsub;
    logic signed [PROD_W-1:0] w_mul;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [DATA_W-1:0] w_res;
    logic                     w_sat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_is_mul   = (r_op == OP_MUL);
    assign w_in_range = (4'(i_in_data.row) < 4'(MAX_DIM)) &&
                        (4'(i_in_data.col) < 4'(MAX_DIM));
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_issue_last = !w_is_mul || (r_k == r_last_idx);

    always_comb begin
        if (r_dim == '0) begin
            w_eff_dim = 4'd1;
        end else if (r_dim > 4'(MAX_DIM)) begin
            w_eff_dim = 4'(MAX_DIM);
        end else begin
            w_eff_dim = r_dim;
        end
    end

    // A product walks row r of A against column c of B; add and subtract
    // read the same element of both matrices.
    assign w_a_raddr = w_is_mul ? elem_addr(r_row, r_k) : elem_addr(r_row, r_col);
    assign w_b_raddr = w_is_mul ? elem_addr(r_k, r_col) : elem_addr(r_row, r_col);
    assign w_waddr   = elem_addr(i_in_data.row, i_in_data.col);

    mas_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (i_in_data.opcode == OP_LOAD_A) && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.value),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    mas_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && (i_in_data.opcode == OP_LOAD_B) && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_in_data.value),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    assign w_mul = $signed(w_a_rdata) * $signed(w_b_rdata);

    always_comb begin
        if (r_op == OP_SUB) begin
            w_addsub = {w_a_rdata[DATA_W-1], w_a_rdata} - {w_b_rdata[DATA_W-1], w_b_rdata};
        end else begin
            w_addsub = {w_a_rdata[DATA_W-1], w_a_rdata} + {w_b_rdata[DATA_W-1], w_b_rdata};
        end
    end

    assign n_acc = (r_p_first ? ACC_W'(0) : r_acc) +
                   {{(ACC_W - PROD_W){r_p[PROD_W-1]}}, r_p};

    // Round half up to Q16.16, then clip: the rounded sum fits 48 bits
    // exactly when all bits from bit 47 upward agree.
    assign w_rnd = r_acc + ACC_W'(32768);

    always_comb begin
        if (w_is_mul) begin
            if (!w_rnd[ACC_W-1] && (|w_rnd[ACC_W-2:47])) begin
                w_sat = 1'b1;
                w_res = {1'b0, {(DATA_W - 1){1'b1}}};
            end else if (w_rnd[ACC_W-1] && !(&w_rnd[ACC_W-2:47])) begin
                w_sat = 1'b1;
                w_res = {1'b1, {(DATA_W - 1){1'b0}}};
            end else begin
                w_sat = 1'b0;
                w_res = w_rnd[47:16];
            end
        end else begin
            if (!r_acc[ACC_W-1] && (|r_acc[ACC_W-2:DATA_W-1])) begin
                w_sat = 1'b1;
                w_res = {1'b0, {(DATA_W - 1){1'b1}}};
            end else if (r_acc[ACC_W-1] && !(&r_acc[ACC_W-2:DATA_W-1])) begin
                w_sat = 1'b1;
                w_res = {1'b1, {(DATA_W - 1){1'b0}}};
            end else begin
                w_sat = 1'b0;
                w_res = r_acc[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dim      <= 4'd8;
            r_op       <= OP_ADD;
            r_last_idx <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
            r_rd_vld   <= 1'b0;
            r_p_vld    <= 1'b0;
            r_acc_done <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dim <= i_cfg_data;
            end

            // Operand pipeline: memory data, operand stage, accumulator.
            r_rd_vld  <= 1'b0;
            r_p_vld   <= r_rd_vld;
            r_p_first <= r_rd_first;
            r_p_last  <= r_rd_last;
            r_p       <= w_is_mul ? w_mul
                                  : {{(PROD_W - DATA_W - 1){w_addsub[DATA_W]}}, w_addsub};
            if (r_p_vld) begin
                r_acc <= n_acc;
                if (r_p_last) begin
                    r_acc_done <= 1'b1;
                end
            end

            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && ((i_in_data.opcode == OP_ADD) ||
                                     (i_in_data.opcode == OP_SUB) ||
                                     (i_in_data.opcode == OP_MUL))) begin
                        r_op       <= i_in_data.opcode;
                        r_last_idx <= 3'(w_eff_dim - 4'd1);
                        r_row      <= '0;
                        r_col      <= '0;
                        r_k        <= '0;
                        r_state    <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_rd_vld   <= 1'b1;
                    r_rd_first <= (r_k == '0);
                    r_rd_last  <= w_issue_last;
                    if (w_issue_last) begin
                        r_k     <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_FIN: begin
                    if (r_acc_done && w_out_free) begin
                        r_acc_done        <= 1'b0;
                        r_out_vld         <= 1'b1;
                        r_out.out_row     <= r_row;
                        r_out.out_col     <= r_col;
                        r_out.result      <= w_res;
                        r_out.saturated   <= w_sat;
                        r_out.last        <= (r_row == r_last_idx) && (r_col == r_last_idx);
                        if (r_col == r_last_idx) begin
                            r_col <= '0;
                            if (r_row == r_last_idx) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_row   <= r_row + 3'd1;
                                r_state <= S_ISSUE;
                            end
                        end else begin
                            r_col   <= r_col + 3'd1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
